// ===== hdl/dad_pkg.sv =====
package dad_pkg;

	localparam int COORD_BITS     = 16;
	localparam int ROTATION_STEPS = 16;
	localparam int TABLE_LEN      = 24;
	localparam int STEP_W         = $clog2(TABLE_LEN);
	localparam int XY_W           = COORD_BITS + ROTATION_STEPS + 3;
	localparam int Z_W            = 24;
	localparam int ANG_W          = 18;
	localparam int ROUND_SHIFT    = 8;
	localparam int ROUND_HALF     = 1 << (ROUND_SHIFT - 1);
	localparam int BASE_W         = Z_W + 1 - ROUND_SHIFT;
	localparam int IN_TDATA_W     = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W    = ((ANG_W + 7) / 8) * 8;

	localparam int QUARTER_TURN       = 90 * 256;
	localparam int HALF_TURN          = 180 * 256;
	localparam int THREE_QUARTER_TURN = 270 * 256;

	typedef struct packed {
		logic                    special;
		logic                    points_equal;
		logic                    neg_dx;
		logic                    neg_dy;
		logic signed [ANG_W-1:0] special_ang;
	} side_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		side_t                  side;
	} cord_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
		logic signed [Z_W-1:0] v;
		unique case (idx)
			5'd0:    v = Z_W'(2949120);
			5'd1:    v = Z_W'(1740967);
			5'd2:    v = Z_W'(919879);
			5'd3:    v = Z_W'(466945);
			5'd4:    v = Z_W'(234379);
			5'd5:    v = Z_W'(117304);
			5'd6:    v = Z_W'(58666);
			5'd7:    v = Z_W'(29335);
			5'd8:    v = Z_W'(14668);
			5'd9:    v = Z_W'(7334);
			5'd10:   v = Z_W'(3667);
			5'd11:   v = Z_W'(1833);
			5'd12:   v = Z_W'(917);
			5'd13:   v = Z_W'(458);
			5'd14:   v = Z_W'(229);
			5'd15:   v = Z_W'(115);
			5'd16:   v = Z_W'(57);
			5'd17:   v = Z_W'(29);
			5'd18:   v = Z_W'(14);
			5'd19:   v = Z_W'(7);
			5'd20:   v = Z_W'(4);
			5'd21:   v = Z_W'(2);
			5'd22:   v = Z_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/dad_prep.sv =====
module dad_prep (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [dad_pkg::COORD_BITS-1:0] from_x,
	input  logic signed [dad_pkg::COORD_BITS-1:0] from_y,
	input  logic signed [dad_pkg::COORD_BITS-1:0] to_x,
	input  logic signed [dad_pkg::COORD_BITS-1:0] to_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output dad_pkg::cord_t                        out_data
);
	import dad_pkg::*;

	logic signed [COORD_BITS:0] dx, dy, adx, ady;
	logic                       ndx, ndy, zdx, zdy;
	cord_t                      nxt;
	cord_t                      data_s1;
	logic                       valid_s1;

	always_comb begin
		dx  = (COORD_BITS+1)'(to_x) - (COORD_BITS+1)'(from_x);
		dy  = (COORD_BITS+1)'(to_y) - (COORD_BITS+1)'(from_y);
		ndx = dx[COORD_BITS];
		ndy = dy[COORD_BITS];
		zdx = (dx == '0);
		zdy = (dy == '0);
		adx = ndx ? -dx : dx;
		ady = ndy ? -dy : dy;

		nxt.x                 = XY_W'({adx[COORD_BITS-1:0], {ROTATION_STEPS{1'b0}}});
		nxt.y                 = XY_W'({ady[COORD_BITS-1:0], {ROTATION_STEPS{1'b0}}});
		nxt.z                 = '0;
		nxt.side.special      = zdx || zdy;
		nxt.side.points_equal = zdx && zdy;
		nxt.side.neg_dx       = ndx;
		nxt.side.neg_dy       = ndy;
		priority if (zdx && zdy) begin
			nxt.side.special_ang = '0;
		end else if (zdx) begin
			nxt.side.special_ang = ndy ? ANG_W'(THREE_QUARTER_TURN) : ANG_W'(QUARTER_TURN);
		end else if (ndx) begin
			nxt.side.special_ang = ANG_W'(HALF_TURN);
		end else begin
			nxt.side.special_ang = '0;
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== hdl/dad_cell.sv =====
module dad_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dad_pkg::STEP_W-1:0]    step,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  dad_pkg::cord_t                in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dad_pkg::cord_t                out_data
);
	import dad_pkg::*;

	logic signed [XY_W-1:0] xs, ys;
	logic signed [Z_W-1:0]  da;
	cord_t                  nxt;
	cord_t                  data_q;
	logic                   valid_q;

	always_comb begin
		xs       = in_data.x >>> step;
		ys       = in_data.y >>> step;
		da       = atan_step(step);
		nxt.side = in_data.side;
		if (!in_data.y[XY_W-1]) begin
			nxt.x = in_data.x + ys;
			nxt.y = in_data.y - xs;
			nxt.z = in_data.z + da;
		end else begin
			nxt.x = in_data.x - ys;
			nxt.y = in_data.y + xs;
			nxt.z = in_data.z - da;
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

endmodule

// ===== hdl/dad_post.sv =====
module dad_post (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  dad_pkg::cord_t                   in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [dad_pkg::ANG_W-1:0] angle_deg,
	output logic                             points_equal
);
	import dad_pkg::*;

	logic [Z_W-1:0]          zc;
	logic [Z_W:0]            zr;
	logic [BASE_W-1:0]       base_raw, base;
	logic signed [ANG_W-1:0] b, ang;
	logic signed [ANG_W-1:0] angle_q;
	logic                    equal_q;
	logic                    valid_q;

	always_comb begin
		zc       = in_data.z[Z_W-1] ? '0 : in_data.z;
		zr       = {1'b0, zc} + (Z_W+1)'(ROUND_HALF);
		base_raw = zr[Z_W:ROUND_SHIFT];
		base     = (base_raw > BASE_W'(QUARTER_TURN - 1)) ? BASE_W'(QUARTER_TURN - 1) : base_raw;
		b        = ANG_W'(base);
		priority if (in_data.side.special) begin
			ang = in_data.side.special_ang;
		end else if (!in_data.side.neg_dx) begin
			ang = in_data.side.neg_dy ? -b : b;
		end else if (in_data.side.neg_dy) begin
			ang = ANG_W'(HALF_TURN) + b;
		end else begin
			ang = ANG_W'(HALF_TURN) - b;
		end
	end

	assign in_ready     = !valid_q || out_ready;
	assign out_valid    = valid_q;
	assign angle_deg    = angle_q;
	assign points_equal = equal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			angle_q <= ang;
			equal_q <= in_data.side.points_equal;
		end
	end

endmodule

// ===== hdl/direction_angle_degrees.sv =====
// Direction from a first point to a second point in units of 1/256 degree, over
// (-90,270]; equal points give 0 with points_equal set. One point pair is taken
// every clock unless backpressure stalls the row: the CORDIC rotations run in a
// row of unrolled cells, one register stage per rotation, between one difference
// stage and one output register. Every stage holds its beat under backpressure
// and a bubble in the row is filled at once.
module direction_angle_degrees (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// from_x, from_y, to_x, to_y
	input  logic [dad_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// angle_deg, zero pad
	output logic [dad_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// points_equal
	output logic                               m_axis_tuser
);
	import dad_pkg::*;

	localparam int CHAIN_LEN = ROTATION_STEPS + 1;

	cord_t                   chain_d [CHAIN_LEN];
	logic                    chain_v [CHAIN_LEN];
	logic                    chain_r [CHAIN_LEN];
	logic signed [ANG_W-1:0] angle_deg;
	logic                    points_equal;

	dad_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.from_x    (s_axis_tdata[COORD_BITS-1:0]),
		.from_y    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
		.to_x      (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
		.to_y      (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
		.out_valid (chain_v[0]),
		.out_ready (chain_r[0]),
		.out_data  (chain_d[0])
	);

	for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_cell
		dad_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (STEP_W'(i)),
			.in_valid  (chain_v[i]),
			.in_ready  (chain_r[i]),
			.in_data   (chain_d[i]),
			.out_valid (chain_v[i+1]),
			.out_ready (chain_r[i+1]),
			.out_data  (chain_d[i+1])
		);
	end

	dad_post u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (chain_v[CHAIN_LEN-1]),
		.in_ready     (chain_r[CHAIN_LEN-1]),
		.in_data      (chain_d[CHAIN_LEN-1]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.angle_deg    (angle_deg),
		.points_equal (points_equal)
	);

	assign m_axis_tdata = OUT_TDATA_W'($unsigned(angle_deg));
	assign m_axis_tuser = points_equal;

	a_equal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && points_equal |-> angle_deg == '0)
		else $error("equal points with nonzero angle");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> angle_deg > -ANG_W'(QUARTER_TURN)
			&& angle_deg <= ANG_W'(THREE_QUARTER_TURN))
		else $error("angle out of range");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

// ===== tb/tb_direction_angle_degrees.sv =====
`timescale 1ns / 100ps

module tb_direction_angle_degrees;

	import dad_pkg::*;

	localparam int LONG_HOLD      = 160;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = ROTATION_STEPS + 24;
	localparam int RANDOM_PAIRS   = 1080;

	// atan(2^-i) in 1/65536 degree
	localparam longint ATAN_Q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct packed {
		logic signed [ANG_W-1:0] angle;
		logic                    coincide;
	} dir_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	logic [IN_TDATA_W-1:0] pending_pairs[$];
	dir_t                  expected_dirs[$];

	int beats_in     = 0;
	int beats_out    = 0;
	int equal_pairs  = 0;
	int axis_pairs   = 0;
	int error_count  = 0;
	int send_gap     = 0;
	int stall_left   = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;
	int idle_cycles  = 0;

	direction_angle_degrees u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic dir_t predict_direction(input logic [IN_TDATA_W-1:0] beat);
		longint dx, dy, x, y, z, xs, ys, b;
		dir_t   r;
		dx = longint'($signed(beat[47:32])) - longint'($signed(beat[15:0]));
		dy = longint'($signed(beat[63:48])) - longint'($signed(beat[31:16]));
		r.coincide = 1'b0;
		if (dx == 0 && dy == 0) begin
			r.angle    = '0;
			r.coincide = 1'b1;
		end else if (dx == 0) begin
			r.angle = (dy > 0) ? ANG_W'(QUARTER_TURN) : ANG_W'(THREE_QUARTER_TURN);
		end else if (dy == 0) begin
			r.angle = (dx > 0) ? '0 : ANG_W'(HALF_TURN);
		end else begin
			x = (dx < 0 ? -dx : dx) <<< ROTATION_STEPS;
			y = (dy < 0 ? -dy : dy) <<< ROTATION_STEPS;
			z = 0;
			for (int i = 0; i < ROTATION_STEPS && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + ATAN_Q16[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - ATAN_Q16[i];
				end
			end
			if (z < 0)
				z = 0;
			b = (z + 128) >>> 8;
			if (b > QUARTER_TURN - 1)
				b = QUARTER_TURN - 1;
			if (dx > 0)
				r.angle = ANG_W'((dy > 0) ? b : -b);
			else
				r.angle = ANG_W'((dy < 0) ? HALF_TURN + b : HALF_TURN - b);
		end
		return r;
	endfunction

	// mostly short gaps, a few long ones, and whole stretches with none
	function automatic int pick_gap(input int n);
		int r;
		r = $urandom_range(0, 99);
		if ((n / 128) % 3 == 0 || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
		error_count++;
		$display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
	endtask

	task automatic add_pair(input logic [15:0] fx, input logic [15:0] fy,
			input logic [15:0] tx, input logic [15:0] ty);
		pending_pairs.push_back({ty, tx, fy, fx});
	endtask

	task automatic add_random_pair();
		logic [15:0] fx, fy, tx, ty;
		int          mode;
		fx   = 16'($urandom);
		fy   = 16'($urandom);
		tx   = 16'($urandom);
		ty   = 16'($urandom);
		mode = $urandom_range(0, 19);
		case (mode)
			0: begin
				tx = fx;
				ty = fy;
			end
			1: tx = fx;
			2: ty = fy;
			3, 4, 5, 6: begin
				fx = 16'($urandom_range(0, 64) - 32);
				fy = 16'($urandom_range(0, 64) - 32);
				tx = 16'($urandom_range(0, 64) - 32);
				ty = 16'($urandom_range(0, 64) - 32);
			end
			7: begin
				// steep or shallow, close to an axis
				tx = fx + 16'($urandom_range(0, 6) - 3);
				ty = fy + 16'($urandom_range(0, 6) - 3);
				if ($urandom_range(0, 1))
					tx = 16'($urandom);
				else
					ty = 16'($urandom);
			end
			8: begin
				// close to a diagonal
				tx = fx + 16'($urandom_range(0, 4000) - 2000);
				ty = fy + ((tx - fx) ^ ($urandom_range(0, 1) ? 16'hffff : 16'h0000))
					+ 16'($urandom_range(0, 4) - 2);
			end
			default: ;
		endcase
		add_pair(fx, fy, tx, ty);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_dirs.push_back(predict_direction(s_axis_tdata));
				beats_in <= beats_in + 1;
				if (s_axis_tdata[15:0] == s_axis_tdata[47:32] &&
						s_axis_tdata[31:16] == s_axis_tdata[63:48])
					equal_pairs <= equal_pairs + 1;
				else if (s_axis_tdata[15:0] == s_axis_tdata[47:32] ||
						s_axis_tdata[31:16] == s_axis_tdata[63:48])
					axis_pairs <= axis_pairs + 1;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (send_gap > 0) begin
					send_gap      <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					s_axis_tdata  <= pending_pairs.pop_front();
					s_axis_tvalid <= 1'b1;
					send_gap      <= pick_gap(beats_in);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with one long hold-off to back up the pipeline
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
			hold_left     <= 0;
			hold_done     <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && beats_in >= 300) begin
			hold_left     <= LONG_HOLD - 1;
			hold_done     <= 1'b1;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			stall_left    <= pick_gap(beats_out + 64);
		end
	end

	// monitor
	always @(posedge clk) begin
		dir_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_out <= beats_out + 1;
			if (expected_dirs.size() == 0) begin
				report_mismatch("unexpected beat, angle", 0, $signed(m_axis_tdata[ANG_W-1:0]));
			end else begin
				want = expected_dirs.pop_front();
				if (m_axis_tdata[ANG_W-1:0] !== want.angle)
					report_mismatch("angle_deg", want.angle,
						$signed(m_axis_tdata[ANG_W-1:0]));
				if (m_axis_tuser !== want.coincide)
					report_mismatch("points_equal", want.coincide, m_axis_tuser);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		// coincident points
		add_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_pair(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		// along the axes
		add_pair(16'h0010, 16'h0020, 16'h0500, 16'h0020);
		add_pair(16'h0500, 16'h0020, 16'h0010, 16'h0020);
		add_pair(16'h0010, 16'h0020, 16'h0010, 16'h0800);
		add_pair(16'h0010, 16'h0800, 16'h0010, 16'h0020);
		add_pair(16'h8000, 16'h0000, 16'h7fff, 16'h0000);
		add_pair(16'h7fff, 16'h0000, 16'h8000, 16'h0000);
		add_pair(16'h0000, 16'h8000, 16'h0000, 16'h7fff);
		add_pair(16'h0000, 16'h7fff, 16'h0000, 16'h8000);
		// diagonals in every quadrant
		add_pair(16'h0000, 16'h0000, 16'h0100, 16'h0100);
		add_pair(16'h0000, 16'h0000, 16'h0100, 16'hff00);
		add_pair(16'h0000, 16'h0000, 16'hff00, 16'hff00);
		add_pair(16'h0000, 16'h0000, 16'hff00, 16'h0100);
		// full-range differences
		add_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		add_pair(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
		add_pair(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		add_pair(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
		// nearly vertical, saturating base angle
		add_pair(16'h0000, 16'h8000, 16'h0001, 16'h7fff);
		add_pair(16'h0000, 16'h8000, 16'hffff, 16'h7fff);
		add_pair(16'h0000, 16'h7fff, 16'h0001, 16'h8000);
		add_pair(16'h0000, 16'h7fff, 16'hffff, 16'h8000);
		// nearly horizontal, and a unit diagonal
		add_pair(16'h8000, 16'h0000, 16'h7fff, 16'h0001);
		add_pair(16'h7fff, 16'h0000, 16'h8000, 16'hffff);
		add_pair(16'h0000, 16'h0000, 16'h0001, 16'h0001);
		repeat (RANDOM_PAIRS)
			add_random_pair();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_pairs.size() > 0 || s_axis_tvalid || expected_dirs.size() > 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d point pairs (%0d coincident, %0d axis-aligned), %0d results",
			beats_in, equal_pairs, axis_pairs, beats_out);
		$display("random idling on both ports plus one %0d-cycle output hold-off", LONG_HOLD);
		if (error_count == 0 && expected_dirs.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", error_count, expected_dirs.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
